// ----- hw/rtl/ahep_pkg.sv -----
// ----------------------------------------------------------------------------
// ahep_pkg
// Types, codes and helper functions for the audio header element parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ahep_pkg;

	localparam int unsigned CfgW  = 8;
	localparam int unsigned WordW = 32;

	localparam logic [WordW-1:0] ALL_ONES     = '1;
	localparam logic [WordW-1:0] RATE_REV3    = 32'd48000;
	localparam logic [WordW-1:0] RATE_DEFAULT = 32'd22050;
	localparam logic [CfgW-1:0]  PLATFORM_PSX = 8'h01;

	// element tags
	localparam logic [7:0] TAG_SUBHDR   = 8'hFD;
	localparam logic [7:0] TAG_END      = 8'hFF;
	localparam logic [7:0] TAG_REVISION = 8'h80;
	localparam logic [7:0] TAG_CHANNELS = 8'h82;
	localparam logic [7:0] TAG_COMPRESS = 8'h83;
	localparam logic [7:0] TAG_RATE     = 8'h84;
	localparam logic [7:0] TAG_SAMPLES  = 8'h85;
	localparam logic [7:0] TAG_SUBEXIT  = 8'h8A;
	localparam logic [7:0] TAG_REV2     = 8'hA0;

	// parse phases
	localparam logic [1:0] PH_TAG   = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;

	// capture targets
	localparam logic [2:0] FLD_DISCARD  = 3'd0;
	localparam logic [2:0] FLD_REVISION = 3'd1;
	localparam logic [2:0] FLD_CHANNELS = 3'd2;
	localparam logic [2:0] FLD_COMPRESS = 3'd3;
	localparam logic [2:0] FLD_RATE     = 3'd4;
	localparam logic [2:0] FLD_SAMPLES  = 3'd5;
	localparam logic [2:0] FLD_REV2     = 3'd6;

	// codec codes
	localparam logic [3:0] CODEC_NONE     = 4'd0;
	localparam logic [3:0] CODEC_PCM16LE  = 4'd1;
	localparam logic [3:0] CODEC_ADPCM_EA = 4'd2;
	localparam logic [3:0] CODEC_R1       = 4'd3;
	localparam logic [3:0] CODEC_R2       = 4'd4;
	localparam logic [3:0] CODEC_R3       = 4'd5;
	localparam logic [3:0] CODEC_PLANAR   = 4'd6;
	localparam logic [3:0] CODEC_MP3      = 4'd7;
	localparam logic [3:0] CODEC_PSX      = 4'd8;

	typedef struct packed {
		logic             in_sub;
		logic [1:0]       phase;
		logic [7:0]       left;
		logic [WordW-1:0] accum;
		logic [2:0]       target;
		logic             exit_after;
		logic [WordW-1:0] revision;
		logic [WordW-1:0] revision2;
		logic [WordW-1:0] compression;
		logic [WordW-1:0] rate;
		logic [WordW-1:0] channels;
		logic [WordW-1:0] samples;
	} parse_t;

	typedef struct packed {
		logic [WordW-1:0] samples;
		logic [WordW-1:0] channels;
		logic [WordW-1:0] rate;
		logic             supported;
		logic [3:0]       codec;
	} result_t;

	localparam parse_t PARSE_CLEAR = '{
		in_sub:      1'b0,
		phase:       PH_TAG,
		left:        8'd0,
		accum:       '0,
		target:      FLD_DISCARD,
		exit_after:  1'b0,
		revision:    ALL_ONES,
		revision2:   ALL_ONES,
		compression: ALL_ONES,
		rate:        ALL_ONES,
		channels:    32'd1,
		samples:     '0
	};

	function automatic logic [2:0] field_of_tag(input logic [7:0] tag);
		logic [2:0] f;
		unique case (tag)
			TAG_REVISION: f = FLD_REVISION;
			TAG_CHANNELS: f = FLD_CHANNELS;
			TAG_COMPRESS: f = FLD_COMPRESS;
			TAG_RATE:     f = FLD_RATE;
			TAG_SAMPLES:  f = FLD_SAMPLES;
			TAG_REV2:     f = FLD_REV2;
			default:      f = FLD_DISCARD;
		endcase
		return f;
	endfunction

	function automatic parse_t commit_value(input parse_t s, input logic [WordW-1:0] v);
		parse_t r;
		r = s;
		unique case (s.target)
			FLD_REVISION: r.revision    = v;
			FLD_CHANNELS: r.channels    = v;
			FLD_COMPRESS: r.compression = v;
			FLD_RATE:     r.rate        = v;
			FLD_SAMPLES:  r.samples     = v;
			FLD_REV2:     r.revision2   = v;
			default:      r.samples     = s.samples;
		endcase
		if (s.exit_after) begin
			r.in_sub = 1'b0;
		end
		r.target     = FLD_DISCARD;
		r.exit_after = 1'b0;
		r.phase      = PH_TAG;
		r.left       = 8'd0;
		return r;
	endfunction

	function automatic result_t decide(input parse_t s, input logic [CfgW-1:0] platform);
		result_t r;
		logic    ok;
		logic [3:0] codec;
		codec = CODEC_NONE;
		ok    = 1'b1;
		if (s.compression == '0) begin
			codec = CODEC_PCM16LE;
		end else if (s.compression == 32'd7) begin
			codec = CODEC_ADPCM_EA;
		end else if (s.compression == ALL_ONES) begin
			case (s.revision)
				32'd1:    codec = CODEC_R1;
				32'd2:    codec = CODEC_R2;
				32'd3:    codec = CODEC_R3;
				ALL_ONES: codec = CODEC_NONE;
				default:  ok = 1'b0;
			endcase
			if (ok) begin
				case (s.revision2)
					32'd8: codec = CODEC_PLANAR;
					32'd10: begin
						if (s.revision == ALL_ONES || s.revision == 32'd2) begin
							codec = CODEC_R1;
						end else if (s.revision == 32'd3) begin
							codec = CODEC_R2;
						end else begin
							ok = 1'b0;
						end
					end
					32'd15, 32'd16: codec = CODEC_MP3;
					ALL_ONES:       codec = codec;
					default: begin
						codec = CODEC_NONE;
						ok    = 1'b0;
					end
				endcase
			end
		end else begin
			ok = 1'b0;
		end
		r.rate = s.rate;
		if (ok) begin
			if (codec == CODEC_NONE && platform == PLATFORM_PSX) begin
				codec = CODEC_PSX;
			end
			if (s.rate == ALL_ONES) begin
				r.rate = (s.revision == 32'd3) ? RATE_REV3 : RATE_DEFAULT;
			end
		end
		r.codec     = codec;
		r.supported = ok;
		r.channels  = s.channels;
		r.samples   = s.samples;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/audio_header_element_parser.sv -----
// ----------------------------------------------------------------------------
// audio_header_element_parser
// Parses a tagged header byte stream and reports the codec, rate, channel
// and sample counts once the header ends.
// ----------------------------------------------------------------------------
// One header byte is taken per clock whenever the result side is not backed
// up; each byte updates the parse state and, when it ends the header (end
// tag or tlast), the classified result is registered into the output
// register, or into the skid entry while the output is occupied. The result
// path holds an output register plus one skid entry, so input is only stalled
// when two results are waiting. The platform register may be written at any
// cycle while the parser is idle; cfg_ready is always high.
`default_nettype none

module audio_header_element_parser
	import ahep_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgW-1:0]    cfg_data,      // platform_id
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,  // data_byte
	input  wire logic               s_axis_tlast,  // stream_end
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// codec_code[3:0], rate_hz[35:4], channel_count[67:36],
	// sample_count[99:68], zero pad[103:100]
	output logic [103:0]            m_axis_tdata,
	output logic [0:0]              m_axis_tuser   // supported
);

	logic [CfgW-1:0] platform_q;
	parse_t          parse_q;
	parse_t          parse_nxt;
	logic            done;
	result_t         res;
	result_t         out_q;
	result_t         skid_q;
	logic            out_valid_q;
	logic            skid_valid_q;
	logic            in_acc;
	logic            out_take;
	logic            push;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !skid_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_take      = out_valid_q && m_axis_tready;

	always_comb begin
		parse_t s;
		s    = parse_q;
		done = 1'b0;
		unique case (parse_q.phase)
			PH_LEN: begin
				if (s_axis_tdata == 8'd0) begin
					s = commit_value(s, '0);
				end else begin
					s.left  = s_axis_tdata;
					s.accum = '0;
					s.phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				s.accum = {parse_q.accum[WordW-9:0], s_axis_tdata};
				s.left  = parse_q.left - 8'd1;
				if (s.left == 8'd0) begin
					s = commit_value(s, s.accum);
				end
			end
			default: begin
				if (s_axis_tdata == TAG_END) begin
					done = 1'b1;
				end else if (!parse_q.in_sub && s_axis_tdata == TAG_SUBHDR) begin
					s.in_sub = 1'b1;
				end else begin
					s.target     = parse_q.in_sub ? field_of_tag(s_axis_tdata) : FLD_DISCARD;
					s.exit_after = parse_q.in_sub && (s_axis_tdata == TAG_SUBEXIT);
					s.phase      = PH_LEN;
				end
			end
		endcase
		if (s_axis_tlast && !done) begin
			if (s.phase == PH_LEN) begin
				s = commit_value(s, '0);
			end else if (s.phase == PH_VALUE) begin
				if (s.left < 8'd4) begin
					s = commit_value(s, s.accum << {s.left[1:0], 3'b000});
				end else begin
					s = commit_value(s, '0);
				end
			end
			done = 1'b1;
		end
		parse_nxt = s;
		res       = decide(s, platform_q);
	end

	assign push = in_acc && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			platform_q <= '0;
			parse_q    <= PARSE_CLEAR;
		end else begin
			if (cfg_valid) begin
				platform_q <= cfg_data;
			end
			if (in_acc) begin
				parse_q <= done ? PARSE_CLEAR : parse_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push && (!out_valid_q || out_take)) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= skid_valid_q;
			end
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end else if (push && out_valid_q) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && skid_valid_q) begin
			out_q <= skid_q;
		end
		if (push) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q.samples, out_q.channels, out_q.rate, out_q.codec};
	assign m_axis_tuser  = out_q.supported;

endmodule

`default_nettype wire
